// ===== rtl/dpf_pkg.sv =====
// ----------------------------------------------------------------------------
// dpf_pkg
// Shared types and constants of the dedup packet FIFO with range count.
// ----------------------------------------------------------------------------
package dpf_pkg;

    // Number of cells in the store
    localparam int DEPTH     = 64;
    // Occupancy holds 0..DEPTH
    localparam int OCC_W     = $clog2(DEPTH + 1);
    // Width of the configured limit; limit and occupancy are compared at LIM_W
    localparam int CFG_W     = 7;
    localparam int CFG_RESET = 64;
    localparam int LIM_W     = (OCC_W > CFG_W) ? OCC_W : CFG_W;

    // Match-count reduction: groups of GRP hit bits, then one final add
    localparam int GRP       = 8;
    localparam int PART_W    = $clog2(GRP + 1);
    localparam int NGRP      = (DEPTH + GRP - 1) / GRP;
    localparam int SUM_W     = (OCC_W > 7) ? OCC_W : 8;
    localparam int CNT_W     = 7;
    localparam int CNT_MAX   = 127;

    // Stream widths
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 80;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_FWD   = 2'd1,
        CMD_COUNT = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_RED,
        S_EXEC
    } state_t;

    // One stored packet, source in the high bits
    typedef struct packed {
        logic [15:0] source;
        logic [15:0] destination;
        logic [31:0] timestamp;
    } entry_t;

    // Broadcast control to every cell
    typedef struct packed {
        logic shift;
        logic cmp_en;
    } cell_ctl_t;

endpackage

// ===== rtl/dpf_cell.sv =====
// ----------------------------------------------------------------------------
// dpf_cell
// One slot of the packet store. Holds an entry, takes its upper neighbor's
// entry on a shift, loads the new packet when selected, and registers its
// duplicate and range-count hits against the broadcast key.
// ----------------------------------------------------------------------------
module dpf_cell (
    input  logic               clk,
    input  dpf_pkg::cell_ctl_t ctl,
    input  logic               valid,
    input  logic               wr_sel,
    input  dpf_pkg::entry_t    key,
    input  logic [31:0]        start_time,
    input  logic [31:0]        end_time,
    input  dpf_pkg::entry_t    nbr_data,
    output dpf_pkg::entry_t    data,
    output logic               dup_hit,
    output logic               cnt_hit
);
    import dpf_pkg::*;

    entry_t data_reg;
    entry_t data_next;
    logic   dup_reg;
    logic   cnt_reg;
    logic   dup_next;
    logic   cnt_next;

    // Load beats shift: the new packet lands after the shift position
    always_comb
    begin
        if (wr_sel)
            data_next = key;
        else if (ctl.shift)
            data_next = nbr_data;
        else
            data_next = data_reg;
    end

    // Per-cell comparators
    always_comb
    begin
        dup_next = valid && (data_reg == key);
        cnt_next = valid && (data_reg.destination == key.destination)
                   && (data_reg.timestamp >= start_time)
                   && (data_reg.timestamp <= end_time);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (ctl.cmp_en)
        begin
            dup_reg <= dup_next;
            cnt_reg <= cnt_next;
        end
    end

    assign data    = data_reg;
    assign dup_hit = dup_reg;
    assign cnt_hit = cnt_reg;

endmodule

// ===== rtl/dpf_count.sv =====
// ----------------------------------------------------------------------------
// dpf_count
// Registered popcount of the cell hit bits: group sums are registered, then
// one final add gives the saturated match count.
// ----------------------------------------------------------------------------
module dpf_count (
    input  logic                      clk,
    input  logic                      en,
    input  logic [dpf_pkg::DEPTH-1:0] hits,
    output logic [dpf_pkg::CNT_W-1:0] count
);
    import dpf_pkg::*;

    logic [NGRP*GRP-1:0]  hits_pad;
    logic [PART_W-1:0]    part_reg  [NGRP];
    logic [PART_W-1:0]    part_next [NGRP];
    logic [SUM_W-1:0]     sum;

    assign hits_pad = (NGRP*GRP)'(hits);

    // Group sums, each over GRP bits
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            part_next[g] = '0;
            for (int j = 0; j < GRP; j++)
                part_next[g] = part_next[g] + PART_W'(hits_pad[g*GRP + j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            for (int g = 0; g < NGRP; g++)
                part_reg[g] <= part_next[g];
    end

    // Final add and saturation
    always_comb
    begin
        sum = '0;
        for (int g = 0; g < NGRP; g++)
            sum = sum + SUM_W'(part_reg[g]);
        count = (sum > SUM_W'(CNT_MAX)) ? CNT_W'(CNT_MAX) : sum[CNT_W-1:0];
    end

endmodule

// ===== rtl/dedup_packet_fifo_with_range_count_top.sv =====
// Sequence: an input transfer goes through the compare, reduce and update steps, and its
// result is registered for the master side; no new item is taken until the update is done.
// The next item is taken while the previous result waits in the output
// register, and an item stalls in its update step until that register frees.
// Reset: rst_n asynchronous, active low; clears occupancy, the sequencer,
// the output valid and sets memory_limit to 64. No clearing pass.
// ----------------------------------------------------------------------------
// dedup_packet_fifo_with_range_count_top
// Bounded packet FIFO built as a shifting row of cells, with a duplicate
// filter on add and a destination/time-range count over the stored packets.
// ----------------------------------------------------------------------------
module dedup_packet_fifo_with_range_count_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration: memory_limit
    input  logic                               cfg_we,
    input  logic [dpf_pkg::CFG_W-1:0]          cfg_wdata,
    // Input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [15:0] source, [31:16] destination, [63:32] timestamp,
    // [95:64] start_time, [127:96] end_time
    input  logic [dpf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]                         s_axis_tuser,
    // Result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] added, [1] forward_valid, [17:2] out_source,
    // [33:18] out_destination, [65:34] out_timestamp, [72:66] match_count,
    // [79:73] zero
    output logic [dpf_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import dpf_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [CFG_W-1:0]    limit_reg;
    logic [OCC_W-1:0]    occ_reg;
    logic [OCC_W-1:0]    occ_next;

    cmd_t                cmd_reg;
    entry_t              key_reg;
    logic [31:0]         lo_reg;
    logic [31:0]         hi_reg;
    logic                dup_reg;

    logic                out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    logic                accept;
    logic                cmp_en;
    logic                red_en;
    logic                exec_go;

    cell_ctl_t           ctl;
    entry_t              cell_data [DEPTH];
    logic [DEPTH-1:0]    valid_vec;
    logic [DEPTH-1:0]    wr_vec;
    logic [DEPTH-1:0]    dup_vec;
    logic [DEPTH-1:0]    cnt_vec;
    logic [CNT_W-1:0]    match_count;

    logic [LIM_W-1:0]    lim_raw;
    logic [LIM_W-1:0]    lim_eff;
    logic                has_data;
    logic                evict;
    logic                add_ok;
    logic                fwd_ok;
    logic [OCC_W-1:0]    wr_idx;

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_axis_tvalid) state_next = S_CMP;
            S_CMP:   state_next = S_RED;
            S_RED:   state_next = S_EXEC;
            S_EXEC:  if (exec_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        cmp_en        = 1'b0;
        red_en        = 1'b0;
        exec_go       = 1'b0;
        unique case (state_reg)
            S_IDLE:  s_axis_tready = 1'b1;
            S_CMP:   cmp_en = 1'b1;
            S_RED:   red_en = 1'b1;
            S_EXEC:  exec_go = !out_valid_reg || m_axis_tready;
            default: s_axis_tready = 1'b0;
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= CFG_W'(CFG_RESET);
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    // Latch the operation at transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg                 <= cmd_t'(s_axis_tuser);
            key_reg.source          <= s_axis_tdata[15:0];
            key_reg.destination     <= s_axis_tdata[31:16];
            key_reg.timestamp       <= s_axis_tdata[63:32];
            lo_reg                  <= s_axis_tdata[95:64];
            hi_reg                  <= s_axis_tdata[127:96];
        end
        if (red_en)
            dup_reg <= |dup_vec;
    end

    // Limit clamp and update decisions
    always_comb
    begin
        lim_raw  = LIM_W'(limit_reg);
        if (lim_raw == '0)
            lim_eff = LIM_W'(1);
        else if (lim_raw > LIM_W'(DEPTH))
            lim_eff = LIM_W'(DEPTH);
        else
            lim_eff = lim_raw;
        has_data = (occ_reg != '0);
        evict    = has_data && (LIM_W'(occ_reg) >= lim_eff);
        add_ok   = exec_go && (cmd_reg == CMD_ADD) && !dup_reg;
        fwd_ok   = exec_go && (cmd_reg == CMD_FWD) && has_data;
        wr_idx   = evict ? (occ_reg - OCC_W'(1)) : occ_reg;
        ctl.cmp_en = cmp_en;
        ctl.shift  = fwd_ok || (add_ok && evict);
    end

    // Occupancy
    always_comb
    begin
        occ_next = occ_reg;
        if (add_ok && !evict)
            occ_next = occ_reg + OCC_W'(1);
        else if (fwd_ok)
            occ_next = occ_reg - OCC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    // Row of cells, cell 0 holds the oldest packet
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t nbr;
        assign valid_vec[i] = (OCC_W'(i) < occ_reg);
        assign wr_vec[i]    = add_ok && (wr_idx == OCC_W'(i));
        if (i == DEPTH - 1)
        begin : g_last
            assign nbr = cell_data[i];
        end
        else
        begin : g_mid
            assign nbr = cell_data[i+1];
        end

        dpf_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .valid      (valid_vec[i]),
            .wr_sel     (wr_vec[i]),
            .key        (key_reg),
            .start_time (lo_reg),
            .end_time   (hi_reg),
            .nbr_data   (nbr),
            .data       (cell_data[i]),
            .dup_hit    (dup_vec[i]),
            .cnt_hit    (cnt_vec[i])
        );
    end

    // Match count reduction
    dpf_count u_count (
        .clk   (clk),
        .en    (red_en),
        .hits  (cnt_vec),
        .count (match_count)
    );

    // Result assembly
    always_comb
    begin
        out_data_next = '0;
        case (cmd_reg)
            CMD_ADD:
                out_data_next[0] = !dup_reg;
            CMD_FWD:
                if (has_data)
                begin
                    out_data_next[1]     = 1'b1;
                    out_data_next[17:2]  = cell_data[0].source;
                    out_data_next[33:18] = cell_data[0].destination;
                    out_data_next[65:34] = cell_data[0].timestamp;
                end
            CMD_COUNT:
                out_data_next[72:66] = match_count;
            default:
                out_data_next = '0;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (exec_go)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== rtl/dpf_checker.sv =====
// ----------------------------------------------------------------------------
// dpf_checker
// Port-level checks of the dedup packet FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module dpf_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [dpf_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import dpf_pkg::*;

    // A stalled result holds its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // One item at a time: busy right after an input transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // Added and forwarded never flag together
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("added and forward_valid both set");

    // A count result carries no other flag
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[72:66] != '0) |-> (m_axis_tdata[1:0] == 2'b00))
        else $error("count result with add or forward flag");

    // No forwarded packet means zero packet fields
    a_fwd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[1] |-> (m_axis_tdata[65:2] == '0))
        else $error("packet fields set without forward");

endmodule

bind dedup_packet_fifo_with_range_count_top dpf_checker u_dpf_checker (.*);
